@@ hdl/egcd_pkg.sv @@
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared types and constants of the extended Euclid unit.
// ----------------------------------------------------------------------------
package egcd_pkg;

   // Default operand width.
   localparam int WIDTH_DEFAULT = 32;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_DONE
   } egcd_state_type;

   // One quotient bit as it leaves the divider, most significant first.
   typedef struct packed {
      logic valid;
      logic value;
   } egcd_qbit_type;

   // Divider status as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } egcd_div_stat_type;

endpackage

@@ hdl/extended_gcd_unit_top.sv @@
// ----------------------------------------------------------------------------
// extended_gcd_unit_top
// Extended Euclid unit: gcd of two unsigned words and their Bezout coefficients.
// ----------------------------------------------------------------------------
// Each request word carries operands a and b; the response word gives
// g = gcd(a, b) and coefficients x, y (two's complement, WIDTH+1 bits) with
// a*x + b*y = g, the ones produced by Euclid's quotient sequence. A request
// runs n Euclid steps, each one division (n is zero when b is zero, at most
// about 47 for 32-bit operands). The step time is set by the divider, which
// produces one quotient bit per cycle while two serial accumulators build the
// coefficient products. One request is processed at a time; a new request is
// taken as soon as the previous result sits in the response register.
module extended_gcd_unit_top #(
   parameter int WIDTH = egcd_pkg::WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [WIDTH-1:0]    req_operand_a,
   input  logic [WIDTH-1:0]    req_operand_b,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WIDTH-1:0]    rsp_divisor,
   output logic signed [WIDTH:0] rsp_coeff_a,
   output logic signed [WIDTH:0] rsp_coeff_b
);
   import egcd_pkg::*;

   egcd_state_type    state_ff, state_in;
   logic [WIDTH-1:0]  ra_ff, ra_in;
   logic [WIDTH-1:0]  rb_ff, rb_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0]  rsp_divisor_ff;
   logic [WIDTH:0]    rsp_coeff_a_ff;
   logic [WIDTH:0]    rsp_coeff_b_ff;
   logic              accept;
   logic              div_start;
   logic              step_update;
   logic              rsp_load;
   egcd_qbit_type     qbit;
   egcd_div_stat_type div_stat;
   logic [WIDTH-1:0]  div_rem;
   logic [WIDTH:0]    xa_cur;
   logic [WIDTH:0]    ya_cur;

   assign accept = req_valid && req_ready;

   // Sequencer: check for a zero divisor, run one division, swap, repeat.
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      div_start    = 1'b0;
      step_update  = 1'b0;
      rsp_load     = 1'b0;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ra_in    = req_operand_a;
               rb_in    = req_operand_b;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (rb_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               step_update = 1'b1;
               ra_in       = rb_ff;
               rb_in       = div_rem;
               state_in    = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Response register holds the result until the consumer takes it.
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      ra_ff <= ra_in;
      rb_ff <= rb_in;
      if (rsp_load) begin
         rsp_divisor_ff <= ra_ff;
         rsp_coeff_a_ff <= xa_cur;
         rsp_coeff_b_ff <= ya_cur;
      end
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   egcd_div #(.WIDTH(WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (ra_ff),
      .divisor   (rb_ff),
      .qbit      (qbit),
      .stat      (div_stat),
      .remainder (div_rem)
   );

   // Coefficients of a start at (1, 0), those of b at (0, 1).
   egcd_coef #(.WIDTH(WIDTH)) u_coef_x (
      .clock    (clock),
      .load     (accept),
      .init_cur ((WIDTH+1)'(1)),
      .init_nxt ((WIDTH+1)'(0)),
      .clear    (div_start),
      .qbit     (qbit),
      .update   (step_update),
      .cur      (xa_cur)
   );

   egcd_coef #(.WIDTH(WIDTH)) u_coef_y (
      .clock    (clock),
      .load     (accept),
      .init_cur ((WIDTH+1)'(0)),
      .init_nxt ((WIDTH+1)'(1)),
      .clear    (div_start),
      .qbit     (qbit),
      .update   (step_update),
      .cur      (ya_cur)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_divisor = rsp_divisor_ff;
   assign rsp_coeff_a = $signed(rsp_coeff_a_ff);
   assign rsp_coeff_b = $signed(rsp_coeff_b_ff);

   // An accepted word always goes to the zero-divisor check first.
   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_CHECK)
      else $error("accepted word did not enter the check state");

   // The divider only reports completion while the sequencer waits for it.
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the division state");

   // A nonzero divisor in the check state starts the divider.
   a_check_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && rb_ff != '0) |=> div_stat.busy)
      else $error("division not started for nonzero divisor");

   // A result is loaded only once the remainder has reached zero.
   a_load_zero_rem: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> rb_ff == '0)
      else $error("result loaded with nonzero remainder");

endmodule

@@ hdl/egcd_div.sv @@
// ----------------------------------------------------------------------------
// egcd_div
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module egcd_div #(
   parameter int WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [WIDTH-1:0]           dividend,
   input  logic [WIDTH-1:0]           divisor,
   output egcd_pkg::egcd_qbit_type    qbit,
   output egcd_pkg::egcd_div_stat_type stat,
   output logic [WIDTH-1:0]           remainder
);
   import egcd_pkg::*;

   localparam int CW = $clog2(WIDTH);

   logic [WIDTH-1:0] dvd_ff, dvd_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;
   logic             ge;
   logic             last;

   // One shift-subtract step on the partial remainder. The partial remainder
   // stays below the divisor, so the top bit of the difference is the borrow.
   always_comb begin
      shifted = {rem_ff, dvd_ff[WIDTH-1]};
      diff    = shifted - {1'b0, divisor};
      ge      = !diff[WIDTH];
      last    = (cnt_ff == CW'(WIDTH - 1));
   end

   // Next values of the divider registers.
   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[WIDTH-2:0], 1'b0};
         rem_in  = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
         cnt_in  = cnt_ff + CW'(1);
         busy_in = !last;
         done_in = last;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign qbit.valid  = busy_ff && !start;
   assign qbit.value  = ge;
   assign stat.busy   = busy_ff;
   assign stat.done   = done_ff;
   assign remainder   = rem_ff;

endmodule

@@ hdl/egcd_coef.sv @@
// ----------------------------------------------------------------------------
// egcd_coef
// One Bezout coefficient pair with a serial quotient-times-coefficient product.
// ----------------------------------------------------------------------------
module egcd_coef #(
   parameter int WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    load,
   input  logic [WIDTH:0]          init_cur,
   input  logic [WIDTH:0]          init_nxt,
   input  logic                    clear,
   input  egcd_pkg::egcd_qbit_type qbit,
   input  logic                    update,
   output logic [WIDTH:0]          cur
);
   import egcd_pkg::*;

   // Values are kept modulo 2^(WIDTH+1); the true coefficients fit there.
   logic [WIDTH:0] cur_ff, cur_in;
   logic [WIDTH:0] nxt_ff, nxt_in;
   logic [WIDTH:0] acc_ff, acc_in;

   // Horner accumulation of q * nxt as quotient bits arrive, then the swap.
   always_comb begin
      cur_in = cur_ff;
      nxt_in = nxt_ff;
      acc_in = acc_ff;
      if (load) begin
         cur_in = init_cur;
         nxt_in = init_nxt;
      end else if (update) begin
         cur_in = nxt_ff;
         nxt_in = cur_ff - acc_ff;
      end
      if (clear) begin
         acc_in = '0;
      end else if (qbit.valid) begin
         acc_in = {acc_ff[WIDTH-1:0], 1'b0} + (qbit.value ? nxt_ff : '0);
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      nxt_ff <= nxt_in;
      acc_ff <= acc_in;
   end

   assign cur = cur_ff;

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the extended Euclid unit.
// ----------------------------------------------------------------------------
// Operand pairs are queued by an initial block: a short directed set (zeros,
// all-ones, equal operands, consecutive Fibonacci numbers for the longest
// quotient chains) followed by random pairs of mixed sizes and shared
// factors. A clocked driver offers them on the request channel with random
// gaps, and a clocked monitor takes response words with random stalls. It
// also holds off once for a long stretch so that the unit backs up. Each
// accepted request is run through an iterative extended Euclid predictor,
// and every response word is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIDTH = egcd_pkg::WIDTH_DEFAULT;
   localparam logic [WIDTH-1:0] ALL_ONES = {WIDTH{1'b1}};
   localparam int QUIET_TAIL = 40;
   localparam int PRESSURE_AT = 30;
   localparam int PRESSURE_CYCLES = 3000;
   localparam int DRAIN_CYCLES = 4 * (WIDTH + 2);

   typedef struct {
      logic [WIDTH-1:0] a;
      logic [WIDTH-1:0] b;
   } operand_pair_type;

   typedef struct {
      logic [WIDTH-1:0]    divisor;
      logic signed [WIDTH:0] coeff_a;
      logic signed [WIDTH:0] coeff_b;
   } gcd_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [WIDTH-1:0]      req_operand_a = '0;
   logic [WIDTH-1:0]      req_operand_b = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [WIDTH-1:0]      rsp_divisor;
   logic signed [WIDTH:0] rsp_coeff_a;
   logic signed [WIDTH:0] rsp_coeff_b;

   operand_pair_type pending_operands[$];
   gcd_result_type   expected_results[$];
   operand_pair_type next_pair;
   gcd_result_type   oldest_result;
   int               request_total;
   int               response_count;
   int               error_count;
   int               send_gap;
   int               hold_left;
   bit               pressure_done;

   extended_gcd_unit_top #(
      .WIDTH(WIDTH)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_divisor  (rsp_divisor),
      .rsp_coeff_a  (rsp_coeff_a),
      .rsp_coeff_b  (rsp_coeff_b)
   );

   always #4 clock = ~clock;

   // Extended Euclid over the quotient sequence. Coefficients run modulo 2^64;
   // their true values fit in WIDTH+1 bits, so the low bits are exact.
   function automatic gcd_result_type gcd_bezout(input logic [WIDTH-1:0] a,
                                                 input logic [WIDTH-1:0] b);
      logic [63:0] rem_hi, rem_lo, xa, xb, ya, yb, q, t;
      gcd_result_type res;
      rem_hi = 64'(a);
      rem_lo = 64'(b);
      xa = 64'd1;
      xb = 64'd0;
      ya = 64'd0;
      yb = 64'd1;
      while (rem_lo != 64'd0) begin
         q = rem_hi / rem_lo;
         t = xa - q * xb;
         xa = xb;
         xb = t;
         t = ya - q * yb;
         ya = yb;
         yb = t;
         t = rem_hi - q * rem_lo;
         rem_hi = rem_lo;
         rem_lo = t;
      end
      res.divisor = rem_hi[WIDTH-1:0];
      res.coeff_a = xa[WIDTH:0];
      res.coeff_b = ya[WIDTH:0];
      return res;
   endfunction

   function automatic void queue_pair(input logic [WIDTH-1:0] a,
                                      input logic [WIDTH-1:0] b);
      operand_pair_type p;
      p.a = a;
      p.b = b;
      pending_operands.push_back(p);
   endfunction

   // Request driver. A word is predicted when it is accepted; after some words
   // a gap of random length with valid low follows, except near the end of the run.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            expected_results.push_back(gcd_bezout(req_operand_a, req_operand_b));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_operands.size() > 0) begin
               next_pair = pending_operands.pop_front();
               req_valid <= 1'b1;
               req_operand_a <= next_pair.a;
               req_operand_b <= next_pair.b;
               if (pending_operands.size() > QUIET_TAIL && $urandom_range(0, 4) == 0)
                  send_gap = $urandom_range(1, 17);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Checks each word against the oldest prediction, stalls
   // in random bursts, and once holds off long enough to back the unit up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         pressure_done = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            response_count = response_count + 1;
            if (expected_results.size() == 0) begin
               error_count = error_count + 1;
               $display("%0t: response word with nothing expected: g=%0h x=%0d y=%0d",
                        $realtime, rsp_divisor, rsp_coeff_a, rsp_coeff_b);
            end else begin
               oldest_result = expected_results.pop_front();
               if (rsp_divisor !== oldest_result.divisor) begin
                  error_count = error_count + 1;
                  $display("%0t: divisor expected %0h actual %0h",
                           $realtime, oldest_result.divisor, rsp_divisor);
               end
               if (rsp_coeff_a !== oldest_result.coeff_a) begin
                  error_count = error_count + 1;
                  $display("%0t: coeff_a expected %0d actual %0d",
                           $realtime, oldest_result.coeff_a, rsp_coeff_a);
               end
               if (rsp_coeff_b !== oldest_result.coeff_b) begin
                  error_count = error_count + 1;
                  $display("%0t: coeff_b expected %0d actual %0d",
                           $realtime, oldest_result.coeff_b, rsp_coeff_b);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (!pressure_done && response_count == PRESSURE_AT) begin
            pressure_done = 1'b1;
            hold_left = PRESSURE_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (response_count < request_total - QUIET_TAIL &&
                      $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 16);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      logic [WIDTH-1:0] a, b, g;
      response_count = 0;
      error_count = 0;

      // Directed words: zero operands, extremes, equal operands and the
      // longest quotient chains from consecutive Fibonacci numbers.
      queue_pair('0, '0);
      queue_pair(ALL_ONES, '0);
      queue_pair('0, ALL_ONES);
      queue_pair('0, 32'd1);
      queue_pair(32'd1, '0);
      queue_pair(32'd9, 32'd9);
      queue_pair(ALL_ONES, ALL_ONES);
      queue_pair(ALL_ONES, 32'd1);
      queue_pair(32'd1, ALL_ONES);
      queue_pair(32'd2971215073, 32'd1836311903);
      queue_pair(32'd1836311903, 32'd2971215073);
      queue_pair(ALL_ONES, ALL_ONES - 1);
      queue_pair(32'h8000_0000, 32'h4000_0000);
      queue_pair(32'h8000_0000, 32'd1);
      queue_pair(32'd240, 32'd46);
      queue_pair(32'd46, 32'd240);
      queue_pair(32'hAAAA_AAAA, 32'h5555_5555);
      queue_pair(32'h5555_5555, 32'hAAAA_AAAA);
      queue_pair(32'(12345 * 65537), 32'(54321 * 65537));
      queue_pair(32'd4294967291, 32'd4294967279);
      queue_pair(32'd6, 32'd4);

      // Random words: full-width pairs, short operands, pairs with a shared
      // factor, and pairs with a zero, a one or equal operands.
      repeat (350) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               a = $urandom;
               b = $urandom;
            end
            4, 5: begin
               a = $urandom >> $urandom_range(0, 31);
               b = $urandom >> $urandom_range(0, 31);
            end
            6, 7: begin
               g = $urandom_range(1, 65535);
               a = g * $urandom_range(0, 65535);
               b = g * $urandom_range(1, 65535);
            end
            default: begin
               a = $urandom;
               case ($urandom_range(0, 3))
                  0: b = '0;
                  1: b = 32'd1;
                  2: b = a;
                  default: begin
                     b = a;
                     a = '0;
                  end
               endcase
            end
         endcase
         queue_pair(a, b);
      end
      request_total = pending_operands.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to go out and every response to come back.
      do
         @(negedge clock);
      while (pending_operands.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   // Watchdog.
   initial begin
      #32_000_000;
      $display("tb_top failed");
      $finish;
   end

endmodule
